// ----- hw/rtl/mrpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Miller-Rabin prime test package
// Shared widths, job and multiplier request and response types, and state encodings.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int WIDTH       = 32;
    localparam int CAND_W      = 32;
    localparam int SHIFT_W     = $clog2(WIDTH);
    localparam int NUM_BASES   = 3;
    localparam int BASE_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [WIDTH-1:0]      word_t;
    typedef logic [SHIFT_W-1:0]    shift_t;
    typedef logic [BASE_IDX_W-1:0] base_idx_t;
    typedef logic [QPTR_W-1:0]     qptr_t;
    typedef logic [QLEVEL_W-1:0]   qlevel_t;

    localparam word_t     BASE_FIRST  = word_t'(2);
    localparam word_t     BASE_SECOND = word_t'(7);
    localparam word_t     BASE_THIRD  = word_t'(61);
    localparam base_idx_t LAST_BASE   = base_idx_t'(NUM_BASES - 1);

    // A job either carries a verdict already known or an odd n with n - 1 = d * 2^s.
    typedef struct packed {
        logic   trivial;
        logic   verdict;
        word_t  n;
        word_t  d;
        shift_t s;
    } job_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t m;
    } mm_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t p;
    } mm_rsp_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_BASE,
        B_WAIT,
        B_EXP,
        B_EXPMUL,
        B_EXPSTEP,
        B_CHECK,
        B_SQR_LOOP,
        B_NEXT,
        B_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_SQR,
        OP_MUL,
        OP_LOOP
    } mm_op_t;

    function automatic word_t base_value(base_idx_t idx);
        word_t v;
        case (idx)
            base_idx_t'(0): v = BASE_FIRST;
            base_idx_t'(1): v = BASE_SECOND;
            default:        v = BASE_THIRD;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/mrpt_if.sv -----
// ----------------------------------------------------------------------------
// Miller-Rabin prime test channels
// Valid/ready channels for candidates and for verdicts.
// ----------------------------------------------------------------------------
interface mrpt_cand_if;

    logic                        valid;
    logic                        ready;
    logic [mrpt_pkg::CAND_W-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);

endinterface

interface mrpt_res_if;

    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink (input valid, input is_prime, output ready);

endinterface

// ----- hw/rtl/mrpt_mulmod.sv -----
// ----------------------------------------------------------------------------
// Modular multiplier
// Computes a * b mod m one bit of a per cycle by shift, add and reduce.
// ----------------------------------------------------------------------------
module mrpt_mulmod
(
    input  logic              clk,
    input  logic              rst_n,
    input  mrpt_pkg::mm_req_t req,
    output mrpt_pkg::mm_rsp_t rsp
);
    import mrpt_pkg::*;

    word_t  a_reg, a_next;
    word_t  b_reg, b_next;
    word_t  m_reg, m_next;
    word_t  r_reg, r_next;
    shift_t cnt_reg, cnt_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    logic [WIDTH:0] dbl;
    logic [WIDTH:0] dbl_red;
    logic [WIDTH:0] sum;
    logic [WIDTH:0] sum_red;
    logic [WIDTH:0] m_ext;

    always_comb
    begin
        m_ext   = {1'b0, m_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = dbl_red + (a_reg[WIDTH-1] ? {1'b0, b_reg} : '0);
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            r_next   = sum_red[WIDTH-1:0];
            a_next   = {a_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - shift_t'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            m_next    = req.m;
            r_next    = '0;
            cnt_next  = shift_t'(WIDTH - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.p    = r_reg;

endmodule

// ----- hw/rtl/mrpt_front.sv -----
// ----------------------------------------------------------------------------
// Miller-Rabin front end
// Takes candidates, settles trivial cases and splits n - 1 into d * 2^s.
// ----------------------------------------------------------------------------
module mrpt_front
(
    input  logic           clk,
    input  logic           rst_n,
    mrpt_cand_if.sink      cand,
    output mrpt_pkg::job_t job,
    output logic           job_valid,
    input  logic           job_ready
);
    import mrpt_pkg::*;

    front_state_t state_reg, state_next;
    word_t        n_reg, n_next;
    word_t        d_reg, d_next;
    shift_t       s_reg, s_next;
    logic         triv_reg, triv_next;
    logic         verdict_reg, verdict_next;
    word_t        n_in;

    assign n_in       = cand.candidate[WIDTH-1:0];
    assign cand.ready = (state_reg == F_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        s_next       = s_reg;
        triv_next    = triv_reg;
        verdict_next = verdict_reg;
        job_valid    = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (cand.valid)
                begin
                    n_next       = n_in;
                    d_next       = n_in - word_t'(1);
                    s_next       = '0;
                    triv_next    = 1'b1;
                    verdict_next = 1'b0;
                    state_next   = F_PUSH;
                    if (n_in == word_t'(2))
                    begin
                        verdict_next = 1'b1;
                    end
                    else if (n_in > word_t'(2) && n_in[0])
                    begin
                        triv_next  = 1'b0;
                        state_next = F_SCAN;
                    end
                end
            end
            F_SCAN:
            begin
                if (d_reg[0])
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    d_next = {1'b0, d_reg[WIDTH-1:1]};
                    s_next = s_reg + shift_t'(1);
                end
            end
            F_PUSH:
            begin
                job_valid = 1'b1;
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        s_reg       <= s_next;
        triv_reg    <= triv_next;
        verdict_reg <= verdict_next;
    end

    assign job.trivial = triv_reg;
    assign job.verdict = verdict_reg;
    assign job.n       = n_reg;
    assign job.d       = d_reg;
    assign job.s       = s_reg;

endmodule

// ----- hw/rtl/mrpt_queue.sv -----
// ----------------------------------------------------------------------------
// Miller-Rabin job queue
// Small register queue between the front end and the test engine.
// ----------------------------------------------------------------------------
module mrpt_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  mrpt_pkg::job_t    in_job,
    input  logic              in_valid,
    output logic              in_ready,
    output mrpt_pkg::job_t    out_job,
    output logic              out_valid,
    input  logic              out_ready,
    output mrpt_pkg::qlevel_t level
);
    import mrpt_pkg::*;

    job_t    entries_reg [QUEUE_DEPTH];
    qptr_t   wr_ptr_reg, wr_ptr_next;
    qptr_t   rd_ptr_reg, rd_ptr_next;
    qlevel_t level_reg, level_next;
    logic    push;
    logic    pop;

    assign in_ready  = (level_reg != qlevel_t'(QUEUE_DEPTH));
    assign out_valid = (level_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = entries_reg[rd_ptr_reg];
    assign level     = level_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + qptr_t'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + qptr_t'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + qlevel_t'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - qlevel_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ----- hw/rtl/mrpt_back.sv -----
// ----------------------------------------------------------------------------
// Miller-Rabin test engine
// Runs the rounds for bases 2, 7 and 61 on a shared modular multiplier.
// ----------------------------------------------------------------------------
module mrpt_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  mrpt_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_ready,
    mrpt_res_if.source     res
);
    import mrpt_pkg::*;

    back_state_t state_reg, state_next;
    mm_op_t      op_reg, op_next;
    word_t       n_reg, n_next;
    word_t       d_reg, d_next;
    shift_t      s_reg, s_next;
    base_idx_t   base_reg, base_next;
    word_t       b_reg, b_next;
    word_t       acc_reg, acc_next;
    shift_t      bit_reg, bit_next;
    shift_t      cnt_reg, cnt_next;
    logic        verdict_reg, verdict_next;
    logic        res_valid_reg, res_valid_next;
    logic        res_bit_reg, res_bit_next;
    word_t       n_minus_1;
    mm_req_t     mm_req;
    mm_rsp_t     mm_rsp;

    mrpt_mulmod u_mulmod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    assign n_minus_1 = n_reg - word_t'(1);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        s_next         = s_reg;
        base_next      = base_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        verdict_next   = verdict_reg;
        res_valid_next = res_valid_reg;
        res_bit_next   = res_bit_reg;
        job_ready      = 1'b0;
        mm_req.start   = 1'b0;
        mm_req.a       = acc_reg;
        mm_req.b       = acc_reg;
        mm_req.m       = n_reg;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    if (job.trivial)
                    begin
                        verdict_next = job.verdict;
                        state_next   = B_OUT;
                    end
                    else
                    begin
                        n_next     = job.n;
                        d_next     = job.d;
                        s_next     = job.s;
                        base_next  = '0;
                        state_next = B_BASE;
                    end
                end
            end
            B_BASE:
            begin
                mm_req.start = 1'b1;
                mm_req.a     = base_value(base_reg);
                mm_req.b     = word_t'(1);
                op_next      = OP_REDUCE;
                state_next   = B_WAIT;
            end
            B_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    unique case (op_reg)
                        OP_REDUCE:
                        begin
                            if (mm_rsp.p == '0)
                            begin
                                state_next = B_NEXT;
                            end
                            else
                            begin
                                b_next     = mm_rsp.p;
                                acc_next   = word_t'(1);
                                bit_next   = shift_t'(WIDTH - 1);
                                state_next = B_EXP;
                            end
                        end
                        OP_SQR:
                        begin
                            acc_next   = mm_rsp.p;
                            state_next = B_EXPMUL;
                        end
                        OP_MUL:
                        begin
                            acc_next   = mm_rsp.p;
                            state_next = B_EXPSTEP;
                        end
                        OP_LOOP:
                        begin
                            acc_next = mm_rsp.p;
                            if (mm_rsp.p == n_minus_1)
                            begin
                                state_next = B_NEXT;
                            end
                            else if (cnt_reg == shift_t'(1))
                            begin
                                verdict_next = 1'b0;
                                state_next   = B_OUT;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg - shift_t'(1);
                                state_next = B_SQR_LOOP;
                            end
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_EXP:
            begin
                if (acc_reg == word_t'(1))
                begin
                    state_next = B_EXPMUL;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    op_next      = OP_SQR;
                    state_next   = B_WAIT;
                end
            end
            B_EXPMUL:
            begin
                state_next = B_EXPSTEP;
                if (d_reg[bit_reg])
                begin
                    if (acc_reg == word_t'(1))
                    begin
                        acc_next = b_reg;
                    end
                    else
                    begin
                        mm_req.start = 1'b1;
                        mm_req.b     = b_reg;
                        op_next      = OP_MUL;
                        state_next   = B_WAIT;
                    end
                end
            end
            B_EXPSTEP:
            begin
                if (bit_reg == '0)
                begin
                    state_next = B_CHECK;
                end
                else
                begin
                    bit_next   = bit_reg - shift_t'(1);
                    state_next = B_EXP;
                end
            end
            B_CHECK:
            begin
                if (acc_reg == word_t'(1) || acc_reg == n_minus_1)
                begin
                    state_next = B_NEXT;
                end
                else if (s_reg <= shift_t'(1))
                begin
                    verdict_next = 1'b0;
                    state_next   = B_OUT;
                end
                else
                begin
                    cnt_next   = s_reg - shift_t'(1);
                    state_next = B_SQR_LOOP;
                end
            end
            B_SQR_LOOP:
            begin
                mm_req.start = 1'b1;
                op_next      = OP_LOOP;
                state_next   = B_WAIT;
            end
            B_NEXT:
            begin
                if (base_reg == LAST_BASE)
                begin
                    verdict_next = 1'b1;
                    state_next   = B_OUT;
                end
                else
                begin
                    base_next  = base_reg + base_idx_t'(1);
                    state_next = B_BASE;
                end
            end
            B_OUT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_bit_next   = verdict_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            op_reg        <= OP_REDUCE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        s_reg       <= s_next;
        base_reg    <= base_next;
        b_reg       <= b_next;
        acc_reg     <= acc_next;
        bit_reg     <= bit_next;
        cnt_reg     <= cnt_next;
        verdict_reg <= verdict_next;
        res_bit_reg <= res_bit_next;
    end

    assign res.valid    = res_valid_reg;
    assign res.is_prime = res_bit_reg;

endmodule

// ----- hw/rtl/miller_rabin_prime_test_unit.sv -----
// Zero, one, two and even candidates are settled in the front end without any modular multiply.
// Odd candidates run a round for each base on the bit-serial multiplier.
// Throughput: one candidate in the engine at a time; the front end and a two-entry
// queue take further candidates while it works. A verdict waits in an output register.
// Reset clears all control state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Miller-Rabin prime test unit
// Deterministic 32-bit primality test with bases 2, 7 and 61.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_unit
(
    input  logic       clk,
    input  logic       rst_n,
    mrpt_cand_if.sink  cand,
    mrpt_res_if.source res
);
    import mrpt_pkg::*;

    job_t    push_job;
    logic    push_valid;
    logic    push_ready;
    job_t    pop_job;
    logic    pop_valid;
    logic    pop_ready;
    qlevel_t q_level;

    mrpt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cand      (cand),
        .job       (push_job),
        .job_valid (push_valid),
        .job_ready (push_ready)
    );

    mrpt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_job    (push_job),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .out_job   (pop_job),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .level     (q_level)
    );

    mrpt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (pop_job),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .res       (res)
    );

    // A job sent to the engine must satisfy n - 1 = d * 2^s with d odd.
    a_split_ok : assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_job.trivial) |->
            (push_job.d[0] && ((push_job.d << push_job.s) == push_job.n - word_t'(1))))
        else $error("front end split of n - 1 is wrong");

    // The only candidate settled as prime without testing is two.
    a_trivial_prime : assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_job.trivial && push_job.verdict) |-> (push_job.n == word_t'(2)))
        else $error("trivial prime verdict for a value other than two");

    // Candidates needing a full test are odd and at least three.
    a_odd_job : assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && !pop_job.trivial) |-> (pop_job.n[0] && pop_job.n > word_t'(2)))
        else $error("engine handed an even or too small candidate");

    // A full queue only stays full or drops by one entry.
    a_level : assert property (@(posedge clk) disable iff (!rst_n)
        (q_level == qlevel_t'(QUEUE_DEPTH)) |=> (q_level == qlevel_t'(QUEUE_DEPTH)
            || q_level == qlevel_t'(QUEUE_DEPTH - 1)))
        else $error("queue level jumped while full");

endmodule
